// ----- sv/tsbm_pkg.sv -----
`default_nettype none

package tsbm_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned NUM_REGS        = 4;
    localparam int unsigned OPCODE_W        = 5;
    localparam int unsigned S_TDATA_W       = 16;
    localparam int unsigned M_TDATA_W       = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD       = 5'd0,
        OP_AND       = 5'd1,
        OP_SUB       = 5'd2,
        OP_OR        = 5'd3,
        OP_SHL       = 5'd4,
        OP_SHR       = 5'd5,
        OP_PUSH1     = 5'd6,
        OP_PUSH2     = 5'd7,
        OP_POP1      = 5'd8,
        OP_POP2      = 5'd9,
        OP_MOV       = 5'd10,
        OP_SAV2      = 5'd11,
        OP_SAV3      = 5'd12,
        OP_OUT       = 5'd13,
        OP_HOST_PUSH = 5'd16,
        OP_HOST_POP  = 5'd17
    } opcode_t;

    // Stage-one beat: either a finished result or a pop waiting on memory data
    typedef struct packed {
        logic       pop;        // value comes from a stack read
        logic       pop_sel2;   // read came from stack two
        logic       pop_empty;  // stack was empty, popped byte is zero
        logic       pop_wr;     // write popped byte to a register
        logic [1:0] pop_dest;
        logic       value_valid;
        logic [7:0] value;
        logic       overflow;
    } s1_t;

endpackage

`default_nettype wire

// ----- sv/two_stack_byte_machine_executor.sv -----
`default_nettype none
// Two-stack byte machine: one instruction per beat.
// The result beat passes through the stage-one register (decode/memory access), then the result register.
// Throughput: one instruction per cycle, no bubbles, unless m_tready stalls the result register; set by the
// single-port access of each stack memory and one register-file update per instruction.
// Reset (rst_n low, asynchronous): general registers, stack counts and pipeline valids clear;
// stack memories are not cleared, only entries below the count are ever read.
module two_stack_byte_machine_executor #(
    parameter int unsigned STACK_DEPTH = tsbm_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tsbm_pkg::S_TDATA_W-1:0] s_tdata,  // [4:0] opcode, [12:5] operand, [15:13] 0
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [tsbm_pkg::M_TDATA_W-1:0]      m_tdata   // [0] value_valid, [8:1] value,
                                                          // [9] overflow, [15:10] 0
);

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [7:0]        gp_reg [tsbm_pkg::NUM_REGS];
    logic [7:0]        gp_next [tsbm_pkg::NUM_REGS];
    logic [CW-1:0]     cnt1_reg, cnt1_next;
    logic [CW-1:0]     cnt2_reg, cnt2_next;

    logic [7:0]        stk1_mem [STACK_DEPTH];
    logic [7:0]        stk2_mem [STACK_DEPTH];
    logic [7:0]        rd1_reg;
    logic [7:0]        rd2_reg;

    logic              s1_valid_reg;
    tsbm_pkg::s1_t     s1_reg, s1_next;

    logic              o_valid_reg;
    logic              o_vv_reg;
    logic [7:0]        o_value_reg;
    logic              o_ovf_reg;

    // ---------------------------------------------------------------
    // Handshake: the result register frees stage one, stage one frees input
    // ---------------------------------------------------------------
    logic out_free;
    logic s1_go;
    logic accept;

    assign out_free = !o_valid_reg || m_tready;
    assign s1_go    = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Stage one: byte popped by the instruction held in stage one, forwarded into register reads
    // ---------------------------------------------------------------
    logic [7:0] pop_data;
    logic [7:0] s1_value;
    logic [7:0] fwd [tsbm_pkg::NUM_REGS];

    always_comb
    begin
        pop_data = s1_reg.pop_empty ? 8'd0 : (s1_reg.pop_sel2 ? rd2_reg : rd1_reg);
        // Only a host pop reports its byte; register pops leave value at zero
        s1_value = (s1_reg.pop && s1_reg.value_valid) ? pop_data : s1_reg.value;
        for (int i = 0; i < tsbm_pkg::NUM_REGS; i++)
        begin
            fwd[i] = (s1_valid_reg && s1_reg.pop && s1_reg.pop_wr && (s1_reg.pop_dest == 2'(i)))
                   ? pop_data : gp_reg[i];
        end
    end

    // ---------------------------------------------------------------
    // Decode and execute
    // ---------------------------------------------------------------
    tsbm_pkg::opcode_t opcode;
    logic [7:0]        operand;
    logic [3:0]        d_idx, s_idx;
    logic [7:0]        a_val, b_val;
    logic              wr_en;
    logic [1:0]        wr_idx;
    logic [7:0]        wr_val;
    logic              push1, push2, pop1, pop2;
    logic [7:0]        push_val;
    logic              full1, full2, empty1, empty2;
    logic [AW-1:0]     wr1_addr, wr2_addr, rd1_addr, rd2_addr;
    logic [CW-1:0]     cnt1_dec, cnt2_dec;

    assign opcode  = tsbm_pkg::opcode_t'(s_tdata[4:0]);
    assign operand = s_tdata[12:5];
    assign d_idx   = operand[7:4];
    assign s_idx   = operand[3:0];
    assign a_val   = (d_idx[3:2] == 2'b00) ? fwd[d_idx[1:0]] : 8'd0;
    assign b_val   = (s_idx[3:2] == 2'b00) ? fwd[s_idx[1:0]] : 8'd0;

    assign full1    = (cnt1_reg == CW'(STACK_DEPTH));
    assign full2    = (cnt2_reg == CW'(STACK_DEPTH));
    assign empty1   = (cnt1_reg == '0);
    assign empty2   = (cnt2_reg == '0);
    assign cnt1_dec = cnt1_reg - 1'b1;
    assign cnt2_dec = cnt2_reg - 1'b1;
    assign wr1_addr = cnt1_reg[AW-1:0];
    assign wr2_addr = cnt2_reg[AW-1:0];
    assign rd1_addr = cnt1_dec[AW-1:0];
    assign rd2_addr = cnt2_dec[AW-1:0];

    always_comb
    begin
        wr_en    = 1'b0;
        wr_idx   = d_idx[1:0];
        wr_val   = 8'd0;
        push1    = 1'b0;
        push2    = 1'b0;
        pop1     = 1'b0;
        pop2     = 1'b0;
        push_val = a_val;
        s1_next  = '0;
        s1_next.pop_dest = d_idx[1:0];
        case (opcode)
            tsbm_pkg::OP_ADD:
            begin
                wr_en  = 1'b1;
                wr_val = a_val + b_val;
            end
            tsbm_pkg::OP_AND:
            begin
                wr_en  = 1'b1;
                wr_val = a_val & b_val;
            end
            tsbm_pkg::OP_SUB:
            begin
                wr_en  = 1'b1;
                wr_val = a_val - b_val;
            end
            tsbm_pkg::OP_OR:
            begin
                wr_en  = 1'b1;
                wr_val = a_val | b_val;
            end
            tsbm_pkg::OP_SHL:
            begin
                wr_en  = 1'b1;
                wr_val = {a_val[6:0], 1'b0};
            end
            tsbm_pkg::OP_SHR:
            begin
                wr_en  = 1'b1;
                wr_val = {1'b0, a_val[7:1]};
            end
            tsbm_pkg::OP_PUSH1:
            begin
                push1            = !full1;
                s1_next.overflow = full1;
            end
            tsbm_pkg::OP_PUSH2:
            begin
                push2            = !full2;
                s1_next.overflow = full2;
            end
            tsbm_pkg::OP_POP1:
            begin
                pop1              = !empty1;
                s1_next.pop       = 1'b1;
                s1_next.pop_empty = empty1;
                s1_next.pop_wr    = (d_idx[3:2] == 2'b00);
            end
            tsbm_pkg::OP_POP2:
            begin
                pop2              = !empty2;
                s1_next.pop       = 1'b1;
                s1_next.pop_sel2  = 1'b1;
                s1_next.pop_empty = empty2;
                s1_next.pop_wr    = (d_idx[3:2] == 2'b00);
            end
            tsbm_pkg::OP_MOV:
            begin
                wr_en  = 1'b1;
                wr_val = b_val;
            end
            tsbm_pkg::OP_SAV2:
            begin
                wr_en  = 1'b1;
                wr_idx = 2'd2;
                wr_val = operand;
            end
            tsbm_pkg::OP_SAV3:
            begin
                wr_en  = 1'b1;
                wr_idx = 2'd3;
                wr_val = operand;
            end
            tsbm_pkg::OP_OUT:
            begin
                s1_next.value_valid = 1'b1;
                s1_next.value       = a_val;
            end
            tsbm_pkg::OP_HOST_PUSH:
            begin
                push1            = !full1;
                push_val         = operand;
                s1_next.overflow = full1;
            end
            tsbm_pkg::OP_HOST_POP:
            begin
                pop2                = !empty2;
                s1_next.pop         = 1'b1;
                s1_next.pop_sel2    = 1'b1;
                s1_next.pop_empty   = empty2;
                s1_next.value_valid = 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
        // ALU-style ops only write real registers; SAV2/SAV3 always target one
        if ((opcode != tsbm_pkg::OP_SAV2) && (opcode != tsbm_pkg::OP_SAV3) && (d_idx[3:2] != 2'b00))
        begin
            wr_en = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Next register file and counts: the younger instruction wins a collision
    // ---------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < tsbm_pkg::NUM_REGS; i++)
        begin
            gp_next[i] = gp_reg[i];
            if (s1_go && s1_reg.pop && s1_reg.pop_wr && (s1_reg.pop_dest == 2'(i)))
            begin
                gp_next[i] = pop_data;
            end
            if (accept && wr_en && (wr_idx == 2'(i)))
            begin
                gp_next[i] = wr_val;
            end
        end
        cnt1_next = cnt1_reg;
        cnt2_next = cnt2_reg;
        if (accept && push1)
        begin
            cnt1_next = cnt1_reg + 1'b1;
        end
        if (accept && pop1)
        begin
            cnt1_next = cnt1_dec;
        end
        if (accept && push2)
        begin
            cnt2_next = cnt2_reg + 1'b1;
        end
        if (accept && pop2)
        begin
            cnt2_next = cnt2_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tsbm_pkg::NUM_REGS; i++)
            begin
                gp_reg[i] <= 8'd0;
            end
            cnt1_reg <= '0;
            cnt2_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < tsbm_pkg::NUM_REGS; i++)
            begin
                gp_reg[i] <= gp_next[i];
            end
            cnt1_reg <= cnt1_next;
            cnt2_reg <= cnt2_next;
        end
    end

    // ---------------------------------------------------------------
    // Stack memories: write on push, registered read on pop; read data
    // holds until the next pop so a stalled beat keeps its byte
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept && push1)
        begin
            stk1_mem[wr1_addr] <= push_val;
        end
        if (accept && pop1)
        begin
            rd1_reg <= stk1_mem[rd1_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && push2)
        begin
            stk2_mem[wr2_addr] <= push_val;
        end
        if (accept && pop2)
        begin
            rd2_reg <= stk2_mem[rd2_addr];
        end
    end

    // ---------------------------------------------------------------
    // Stage one register and result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go)
            begin
                o_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_go)
        begin
            o_vv_reg    <= s1_reg.value_valid;
            o_value_reg <= s1_value;
            o_ovf_reg   <= s1_reg.overflow;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {6'd0, o_ovf_reg, o_value_reg, o_vv_reg};

endmodule

`default_nettype wire

// ----- sv/tsbm_checker.sv -----
`default_nettype none

module tsbm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed under stall");

    // Keep padding bits clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:10] == 6'd0))
        else $error("result padding not zero");

    // Report no value without value_valid
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[8:1] == 8'd0))
        else $error("value set without value_valid");

    // Flag overflow only for pushes, which never report a value
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
        else $error("value_valid and overflow both set");

    // Be ready for input while no result beat is held and the sampled past s_tvalid was low
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && !$past(s_tvalid) |-> s_tready)
        else $error("input stalled with empty pipeline");

endmodule

bind two_stack_byte_machine_executor tsbm_checker u_tsbm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
